/* rtl/etfp_pkg.sv */
// Shared types and constants for the Ethernet transmit framer and padder.
// Holds the command item passed from the front end to the byte emitter.
// No dependencies.
`timescale 1ns / 1ps

package etfp_pkg;

	localparam int MAC_W          = 48;
	localparam int TYPE_W         = 16;
	localparam int LEN_W          = 11;
	localparam int BYTE_W         = 8;
	localparam int IDX_W          = 6;    // result index within one command, 0..63
	localparam int HDR_BYTES      = 14;
	localparam int FCS_BYTES      = 4;
	localparam int RESULT_BUDGET  = 64;

	localparam int DEF_MIN_PAYLOAD = 46;
	localparam int DEF_MAX_PAYLOAD = 1500;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_REJECT = 2'd2
	} cmd_kind_t;

	// One command: a run of output bytes produced by a single accepted item.
	typedef struct packed {
		cmd_kind_t               kind;
		logic [MAC_W-1:0]        dest_mac;
		logic [TYPE_W-1:0]       ether_type;
		logic [BYTE_W-1:0]       data_byte;
		logic                    close;     // run ends the frame: last mark on final byte
		logic [IDX_W-1:0]        last_idx;  // index of the final byte of the run
	} cmd_t;

endpackage

/* rtl/ethernet_tx_framer_padder.sv */
// Top level of the Ethernet transmit framer and padder.
// Depends on etfp_pkg, etfp_front, etfp_queue and etfp_back.
//
//   channel  signals                                               dir  handshake
//   in       req_type dest_mac ether_type payload_len payload_byte in   in_valid / in_stall
//   out      out_byte out_last status                              out  out_valid / out_stall
//   cfg      cfg_wr_data (source_mac)                              in   cfg_wr_en
//
// A payload item that does not close its frame leaves as one byte. A start item yields
// 14 header bytes (a too-long one yields a reject byte); a closing item adds padding and
// four zero bytes in the FCS slots. Each run has at most 64 bytes, one per cycle from the
// emitter while out_stall is low. The front end keeps accepting while the command queue
// has room. Reset clears frame state, queue and output valid; source_mac resets to zero.
// out_stall holds the output register; in_stall rises only when the queue is full.
`timescale 1ns / 1ps

module ethernet_tx_framer_padder import etfp_pkg::*; #(
	parameter int MIN_PAYLOAD = DEF_MIN_PAYLOAD,
	parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [MAC_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [MAC_W-1:0]  dest_mac,
	input  logic [TYPE_W-1:0] ether_type,
	input  logic [LEN_W-1:0]  payload_len,
	input  logic [BYTE_W-1:0] payload_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last,
	output logic              status
);

	logic [MAC_W-1:0] source_mac_q;
	logic             q_full;
	logic             q_empty;
	logic             accept;
	logic             push;
	logic             pop;
	cmd_t             wr_cmd;
	cmd_t             head;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mac_q <= '0;
		end else if (cfg_wr_en) begin
			source_mac_q <= cfg_wr_data;
		end
	end

	etfp_front #(
		.MIN_PAYLOAD (MIN_PAYLOAD),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.dest_mac     (dest_mac),
		.ether_type   (ether_type),
		.payload_len  (payload_len),
		.payload_byte (payload_byte),
		.push         (push),
		.cmd          (wr_cmd)
	);

	etfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	etfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.source_mac (source_mac_q),
		.head       (head),
		.empty      (q_empty),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.status     (status)
	);

endmodule

/* rtl/etfp_front.sv */
// Front end: accepts items, tracks the open frame and turns each item into a command.
// Depends on etfp_pkg.
`timescale 1ns / 1ps

module etfp_front import etfp_pkg::*; #(
	parameter int MIN_PAYLOAD = DEF_MIN_PAYLOAD,
	parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              req_type,
	input  logic [MAC_W-1:0]  dest_mac,
	input  logic [TYPE_W-1:0] ether_type,
	input  logic [LEN_W-1:0]  payload_len,
	input  logic [BYTE_W-1:0] payload_byte,
	output logic              push,
	output cmd_t              cmd
);

	localparam logic [LEN_W-1:0] MinLen = LEN_W'(MIN_PAYLOAD);
	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PAYLOAD);

	logic             open_q;
	logic             rejecting_q;
	logic [LEN_W-1:0] decl_q;
	logic [LEN_W-1:0] taken_q;

	logic             is_start;
	logic             too_long;
	logic [LEN_W-1:0] taken_n;
	logic             done;
	logic             close;
	logic [LEN_W-1:0] pad_base;
	logic [LEN_W-1:0] pad_full;
	logic [7:0]       tail;
	logic [7:0]       total;

	assign is_start = (req_type == REQ_START);
	assign too_long = (payload_len > MaxLen);
	assign taken_n  = taken_q + LEN_W'(1);
	assign done     = (taken_n >= decl_q);
	assign close    = is_start ? (payload_len == '0) : done;

	// padding up to the minimum payload, then FCS; whole run capped at the budget
	assign pad_base = is_start ? '0 : decl_q;
	assign pad_full = (pad_base < MinLen) ? (MinLen - pad_base) : '0;
	assign tail     = close ? (8'(pad_full) + 8'(FCS_BYTES)) : '0;
	assign total    = (is_start ? 8'(HDR_BYTES) : 8'd1) + tail;

	always_comb begin
		cmd.dest_mac   = dest_mac;
		cmd.ether_type = ether_type;
		cmd.data_byte  = payload_byte;
		cmd.close      = close;
		cmd.last_idx   = (total > 8'(RESULT_BUDGET)) ? IDX_W'(RESULT_BUDGET - 1)
		                                             : IDX_W'(total - 8'd1);
		if (is_start && too_long) begin
			cmd.kind     = KIND_REJECT;
			cmd.close    = 1'b1;
			cmd.last_idx = '0;
		end else if (is_start) begin
			cmd.kind = KIND_HEADER;
		end else begin
			cmd.kind = KIND_DATA;
		end
		push = accept && (is_start || (open_q && !rejecting_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			rejecting_q <= 1'b0;
			decl_q      <= '0;
			taken_q     <= '0;
		end else if (accept) begin
			if (is_start) begin
				decl_q      <= payload_len;
				taken_q     <= '0;
				open_q      <= too_long || (payload_len != '0);
				rejecting_q <= too_long;
			end else if (open_q) begin
				taken_q <= taken_n;
				if (done) begin
					open_q      <= 1'b0;
					rejecting_q <= 1'b0;
				end
			end
		end
	end

	a_rej_open: assert property (@(posedge clk) disable iff (!arst_n)
		rejecting_q |-> open_q)
		else $error("rejecting with no open frame");

	a_taken_below: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (taken_q < decl_q))
		else $error("open frame has taken all its bytes");

	a_stray_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_PAYLOAD) && !open_q) |-> !push)
		else $error("stray byte produced a command");

endmodule

/* rtl/etfp_queue.sv */
// Short command queue between the front end and the byte emitter.
// Depends on etfp_pkg.
`timescale 1ns / 1ps

module etfp_queue import etfp_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH   // at least 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic empty,
	output logic full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty  = (count_q == '0);
	assign full   = (count_q == CW'(DEPTH));
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step with count");

endmodule

/* rtl/etfp_back.sv */
// Byte emitter: expands the command at the queue head into frame bytes, one per cycle unless stalled.
// Depends on etfp_pkg.
`timescale 1ns / 1ps

module etfp_back import etfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MAC_W-1:0]  source_mac,
	input  cmd_t              head,
	input  logic              empty,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last,
	output logic              status
);

	logic [IDX_W-1:0]  n_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              status_q;

	logic              adv;
	logic              at_end;
	logic [2:0]        dst_k;
	logic [2:0]        src_k;
	logic [BYTE_W-1:0] byte_d;

	assign adv    = !valid_q || !out_stall;
	assign at_end = (n_q == head.last_idx);
	assign pop    = adv && !empty && at_end;

	// byte positions within each address, most significant first
	assign dst_k = 3'(3'd5 - n_q[2:0]);
	assign src_k = 3'(4'd11 - n_q[3:0]);

	always_comb begin
		byte_d = '0;
		unique case (head.kind)
			KIND_HEADER: begin
				priority if (n_q < IDX_W'(6)) begin
					byte_d = head.dest_mac[{dst_k, 3'b000} +: BYTE_W];
				end else if (n_q < IDX_W'(12)) begin
					byte_d = source_mac[{src_k, 3'b000} +: BYTE_W];
				end else if (n_q == IDX_W'(12)) begin
					byte_d = head.ether_type[15:8];
				end else if (n_q == IDX_W'(13)) begin
					byte_d = head.ether_type[7:0];
				end else begin
					byte_d = '0;
				end
			end
			KIND_DATA: begin
				byte_d = (n_q == '0) ? head.data_byte : '0;
			end
			default: begin
				byte_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= !empty;
			if (!empty) begin
				n_q <= at_end ? '0 : n_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !empty) begin
			byte_q   <= byte_d;
			last_q   <= head.close && at_end;
			status_q <= (head.kind == KIND_REJECT) ? STATUS_REJECT : STATUS_OK;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign status    = status_q;

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (n_q == '0))
		else $error("run index left over with queue empty");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (n_q <= head.last_idx))
		else $error("run index past end of command");

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (status_q == STATUS_REJECT)) |-> last_q)
		else $error("reject result without last mark");

endmodule
